// ===== rtl/bencode_stream_tokenizer_macros.svh =====
// assertion macros for the bencode stream tokenizer
`ifndef BENCODE_STREAM_TOKENIZER_MACROS_SVH
`define BENCODE_STREAM_TOKENIZER_MACROS_SVH

// same-cycle implication
`define BST_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bst_pkg.sv =====
// types, codes and helpers shared by the bencode stream tokenizer
package bst_pkg;

    localparam int DEPTH_W = 6;
    localparam int FRAME_W = 34;

    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;

    localparam logic [2:0] K_DICT  = 3'd0;
    localparam logic [2:0] K_LIST  = 3'd1;
    localparam logic [2:0] K_END   = 3'd2;
    localparam logic [2:0] K_INT   = 3'd3;
    localparam logic [2:0] K_SHDR  = 3'd4;
    localparam logic [2:0] K_SBYTE = 3'd5;
    localparam logic [2:0] K_ERR   = 3'd6;
    localparam logic [2:0] K_UNTERM = 3'd7;

    localparam logic [2:0] E_ILLEGAL  = 3'd0;
    localparam logic [2:0] E_KEY      = 3'd1;
    localparam logic [2:0] E_NUMBER   = 3'd2;
    localparam logic [2:0] E_INT_END  = 3'd3;
    localparam logic [2:0] E_STR_END  = 3'd4;
    localparam logic [2:0] E_DEEP     = 3'd5;

    localparam logic [1:0] FK_DKEY = 2'd0;
    localparam logic [1:0] FK_LIST = 2'd1;
    localparam logic [1:0] FK_DVAL = 2'd2;

    typedef enum logic [2:0] {
        PH_VALUE = 3'd0,
        PH_ISIGN = 3'd1,
        PH_IDIG  = 3'd2,
        PH_SLEN  = 3'd3,
        PH_SBODY = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [63:0]        value;
        logic               wide;
        logic [31:0]        offset;
        logic [31:0]        length;
        logic [DEPTH_W-1:0] depth;
        logic [2:0]         error_code;
        logic               is_key;
        logic               last;
    } res_t;

    function automatic res_t mk_res(input logic [2:0] kind, input logic [63:0] value,
                                    input logic wide, input logic [31:0] offset,
                                    input logic [31:0] length,
                                    input logic [DEPTH_W-1:0] depth,
                                    input logic [2:0] err, input logic key);
        res_t r;
        r.kind       = kind;
        r.value      = value;
        r.wide       = wide;
        r.offset     = offset;
        r.length     = length;
        r.depth      = depth;
        r.error_code = err;
        r.is_key     = key;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/bst_ram.sv =====
// generic single-write, single-read ram with registered read data
module bst_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bencode_stream_tokenizer.sv =====
// top level of the bencode stream tokenizer
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  cfg     | in        | cfg_wr_en         | cfg_wr_data (base_offset)
//  s_      | in        | s_valid/s_ready   | byte_in, first, final_req
//  m_      | out       | m_valid/m_ready   | kind, value, wide, offset, length, depth,
//          |           |                   | error_code, is_key, last
//
// one byte per cycle while s_ready is high; each byte updates state in the cycle it is accepted
// the frame stack sits in a ram; the top frame is cached in registers and the
// frame below it is prefetched every cycle, with forwarding on push
// results go to a four-entry queue; s_ready drops while fewer than two slots are free
// reset is synchronous and needs no clearing pass
`include "bencode_stream_tokenizer_macros.svh"

module bencode_stream_tokenizer #(
    parameter int STACK_DEPTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_byte_in,
    input  logic               s_first,
    input  logic               s_final_req,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_kind,
    output logic signed [63:0] m_value,
    output logic               m_wide,
    output logic [31:0]        m_offset,
    output logic [31:0]        m_length,
    output logic [5:0]         m_depth,
    output logic [2:0]         m_error_code,
    output logic               m_is_key,
    output logic               m_last
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = bst_pkg::DEPTH_W;
    localparam int FW = bst_pkg::FRAME_W;

    logic [31:0]          base_reg;
    logic [31:0]          pos_reg, pos_next;
    logic [DW-1:0]        depth_reg, depth_next;
    bst_pkg::phase_t      phase_reg, phase_next;
    logic [63:0]          acc_reg, acc_next;
    logic                 neg_reg, neg_next;
    logic                 seen_reg, seen_next;
    logic [31:0]          rem_reg, rem_next;
    logic [31:0]          tok_reg, tok_next;
    logic                 halt_reg, halt_next;
    logic [1:0]           top_kind_reg, top_kind_next;
    logic [31:0]          top_start_reg, top_start_next;
    logic [31:0]          root_reg, root_next;
    logic                 fwd_reg, fwd_next;
    logic [FW-1:0]        fwd_data_reg;

    logic [31:0]          pos_c;
    logic [DW-1:0]        depth_c;
    bst_pkg::phase_t      phase_c;
    logic [63:0]          acc_c;
    logic                 neg_c, seen_c, halt_c;
    logic [31:0]          rem_c, tok_c;

    logic                 in_acc, out_acc;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [FW-1:0]        mem_wdata, ram_q, below;
    logic                 pop, vdone, a_v, b_v;
    bst_pkg::res_t        res0, res1, slot0, slot1, head;
    logic                 is_digit, in_dkey;
    logic [3:0]           dig;
    logic [67:0]          acc_x10, int_lim;
    logic [31:0]          slen;
    logic [DW-1:0]        depth_m1;

    bst_pkg::res_t        fifo_reg [4];
    logic [1:0]           wr_ptr_reg, rd_ptr_reg;
    logic [2:0]           cnt_reg, cnt_next;
    logic                 wr0, wr1;

    bst_ram #(.WIDTH(FW), .DEPTH(STACK_DEPTH)) u_frames (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (ram_q)
    );

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;
    assign s_ready = (cnt_reg <= 3'd2);
    assign m_valid = (cnt_reg != 3'd0);
    assign below   = fwd_reg ? fwd_data_reg : ram_q;

    assign is_digit = (s_byte_in >= bst_pkg::CH_0) && (s_byte_in <= bst_pkg::CH_9);
    assign dig      = 4'(s_byte_in - bst_pkg::CH_0);
    assign pos_c    = s_first ? 32'd0 : pos_reg;
    assign depth_c  = s_first ? '0 : depth_reg;
    assign phase_c  = s_first ? bst_pkg::PH_VALUE : phase_reg;
    assign acc_c    = s_first ? 64'd0 : acc_reg;
    assign neg_c    = s_first ? 1'b0 : neg_reg;
    assign seen_c   = s_first ? 1'b0 : seen_reg;
    assign rem_c    = s_first ? 32'd0 : rem_reg;
    assign tok_c    = s_first ? 32'd0 : tok_reg;
    assign halt_c   = s_first ? 1'b0 : halt_reg;
    assign acc_x10  = ({4'd0, acc_c} << 3) + ({4'd0, acc_c} << 1) + 68'(dig);
    assign int_lim  = neg_c ? 68'h0_8000_0000_0000_0000 : 68'h0_7FFF_FFFF_FFFF_FFFF;
    assign in_dkey  = (depth_c != '0) && (top_kind_reg == bst_pkg::FK_DKEY);
    assign slen     = acc_c[31:0];
    assign depth_m1 = depth_c - DW'(1);

    always_comb begin
        pos_next       = pos_reg;
        depth_next     = depth_reg;
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        seen_next      = seen_reg;
        rem_next       = rem_reg;
        tok_next       = tok_reg;
        halt_next      = halt_reg;
        top_kind_next  = top_kind_reg;
        top_start_next = top_start_reg;
        root_next      = root_reg;
        res0           = '0;
        res1           = '0;
        a_v            = 1'b0;
        b_v            = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = depth_m1[AW-1:0];
        mem_wdata      = {top_kind_reg, top_start_reg};
        pop            = 1'b0;
        vdone          = 1'b0;
        if (in_acc) begin
            pos_next   = pos_c + 32'd1;
            depth_next = depth_c;
            phase_next = phase_c;
            acc_next   = acc_c;
            neg_next   = neg_c;
            seen_next  = seen_c;
            rem_next   = rem_c;
            tok_next   = tok_c;
            halt_next  = halt_c;
            if (!halt_c) begin
                unique case (phase_c)
                    bst_pkg::PH_VALUE: begin
                        priority if (s_byte_in == bst_pkg::CH_E) begin
                            if (depth_c == '0 || top_kind_reg == bst_pkg::FK_DVAL) begin
                                a_v = 1'b1;
                                res0 = bst_pkg::mk_res(bst_pkg::K_ERR, 64'd0, 1'b0,
                                    base_reg + pos_c, 32'd0, depth_c,
                                    bst_pkg::E_ILLEGAL, 1'b0);
                                halt_next = 1'b1;
                            end else begin
                                a_v = 1'b1;
                                res0 = bst_pkg::mk_res(bst_pkg::K_END, 64'd0, 1'b0,
                                    base_reg + top_start_reg,
                                    pos_c - top_start_reg + 32'd1, depth_m1,
                                    bst_pkg::E_ILLEGAL, 1'b0);
                                depth_next = depth_m1;
                                pop = 1'b1;
                                vdone = 1'b1;
                            end
                        end else if (is_digit) begin
                            tok_next = pos_c;
                            acc_next = 64'(dig);
                            phase_next = bst_pkg::PH_SLEN;
                        end else if (s_byte_in == bst_pkg::CH_D || s_byte_in == bst_pkg::CH_L
                                     || s_byte_in == bst_pkg::CH_I) begin
                            if (in_dkey) begin
                                a_v = 1'b1;
                                res0 = bst_pkg::mk_res(bst_pkg::K_ERR, 64'd0, 1'b0,
                                    base_reg + pos_c, 32'd0, depth_c,
                                    bst_pkg::E_KEY, 1'b0);
                                halt_next = 1'b1;
                            end else if (s_byte_in == bst_pkg::CH_I) begin
                                tok_next = pos_c;
                                acc_next = 64'd0;
                                neg_next = 1'b0;
                                seen_next = 1'b0;
                                phase_next = bst_pkg::PH_ISIGN;
                            end else if (depth_c >= DW'(STACK_DEPTH)) begin
                                a_v = 1'b1;
                                res0 = bst_pkg::mk_res(bst_pkg::K_ERR, 64'd0, 1'b0,
                                    base_reg + pos_c, 32'd0, depth_c,
                                    bst_pkg::E_DEEP, 1'b0);
                                halt_next = 1'b1;
                            end else begin
                                a_v = 1'b1;
                                res0 = bst_pkg::mk_res(
                                    (s_byte_in == bst_pkg::CH_D) ? bst_pkg::K_DICT
                                                                 : bst_pkg::K_LIST,
                                    64'd0, 1'b0, base_reg + pos_c, 32'd0, depth_c,
                                    bst_pkg::E_ILLEGAL, 1'b0);
                                mem_we = (depth_c != '0);
                                top_kind_next = (s_byte_in == bst_pkg::CH_D) ?
                                    bst_pkg::FK_DKEY : bst_pkg::FK_LIST;
                                top_start_next = pos_c;
                                if (depth_c == '0) begin
                                    root_next = pos_c;
                                end
                                depth_next = depth_c + DW'(1);
                            end
                        end else begin
                            a_v = 1'b1;
                            res0 = bst_pkg::mk_res(bst_pkg::K_ERR, 64'd0, 1'b0,
                                base_reg + pos_c, 32'd0, depth_c,
                                bst_pkg::E_ILLEGAL, 1'b0);
                            halt_next = 1'b1;
                        end
                    end
                    bst_pkg::PH_ISIGN, bst_pkg::PH_IDIG: begin
                        priority if (phase_c == bst_pkg::PH_ISIGN
                                     && s_byte_in == bst_pkg::CH_MINUS) begin
                            neg_next = 1'b1;
                            phase_next = bst_pkg::PH_IDIG;
                        end else if (phase_c == bst_pkg::PH_ISIGN
                                     && s_byte_in == bst_pkg::CH_PLUS) begin
                            phase_next = bst_pkg::PH_IDIG;
                        end else if (is_digit) begin
                            if (acc_x10 > int_lim) begin
                                a_v = 1'b1;
                                res0 = bst_pkg::mk_res(bst_pkg::K_ERR, 64'd0, 1'b0,
                                    base_reg + pos_c, 32'd0, depth_c,
                                    bst_pkg::E_NUMBER, 1'b0);
                                halt_next = 1'b1;
                            end else begin
                                acc_next = acc_x10[63:0];
                                seen_next = 1'b1;
                                phase_next = bst_pkg::PH_IDIG;
                            end
                        end else if (phase_c == bst_pkg::PH_IDIG
                                     && s_byte_in == bst_pkg::CH_E && seen_c) begin
                            a_v = 1'b1;
                            res0 = bst_pkg::mk_res(bst_pkg::K_INT,
                                neg_c ? (64'd0 - acc_c) : acc_c,
                                neg_c ? (acc_c > 64'h8000_0000) : (acc_c > 64'h7FFF_FFFF),
                                base_reg + tok_c, pos_c - tok_c + 32'd1, depth_c,
                                bst_pkg::E_ILLEGAL, 1'b0);
                            vdone = 1'b1;
                        end else begin
                            a_v = 1'b1;
                            res0 = bst_pkg::mk_res(bst_pkg::K_ERR, 64'd0, 1'b0,
                                base_reg + pos_c, 32'd0, depth_c,
                                bst_pkg::E_NUMBER, 1'b0);
                            halt_next = 1'b1;
                        end
                    end
                    bst_pkg::PH_SLEN: begin
                        priority if (is_digit) begin
                            acc_next = acc_x10[63:0];
                            if (acc_x10 > 68'h7FFF_FFFF) begin
                                a_v = 1'b1;
                                res0 = bst_pkg::mk_res(bst_pkg::K_ERR, 64'd0, 1'b0,
                                    base_reg + pos_c, 32'd0, depth_c,
                                    bst_pkg::E_NUMBER, 1'b0);
                                halt_next = 1'b1;
                            end
                        end else if (s_byte_in == bst_pkg::CH_COLON) begin
                            a_v = 1'b1;
                            res0 = bst_pkg::mk_res(bst_pkg::K_SHDR, {32'd0, slen}, 1'b0,
                                base_reg + tok_c, pos_c - tok_c + 32'd1 + slen, depth_c,
                                bst_pkg::E_ILLEGAL, in_dkey);
                            rem_next = slen;
                            if (slen == 32'd0) begin
                                vdone = 1'b1;
                            end else begin
                                phase_next = bst_pkg::PH_SBODY;
                            end
                        end else begin
                            a_v = 1'b1;
                            res0 = bst_pkg::mk_res(bst_pkg::K_ERR, 64'd0, 1'b0,
                                base_reg + pos_c, 32'd0, depth_c,
                                bst_pkg::E_NUMBER, 1'b0);
                            halt_next = 1'b1;
                        end
                    end
                    bst_pkg::PH_SBODY: begin
                        a_v = 1'b1;
                        res0 = bst_pkg::mk_res(bst_pkg::K_SBYTE, {56'd0, s_byte_in}, 1'b0,
                            base_reg + tok_c, 32'd0, depth_c, bst_pkg::E_ILLEGAL, in_dkey);
                        rem_next = rem_c - 32'd1;
                        if (rem_c == 32'd1) begin
                            vdone = 1'b1;
                        end
                    end
                    bst_pkg::PH_DONE: begin
                    end
                    default: begin
                    end
                endcase
            end
            if (pop) begin
                top_kind_next  = below[FW-1:32];
                top_start_next = below[31:0];
            end
            if (vdone) begin
                if (depth_next == '0) begin
                    phase_next = bst_pkg::PH_DONE;
                end else begin
                    if (top_kind_next == bst_pkg::FK_DKEY) begin
                        top_kind_next = bst_pkg::FK_DVAL;
                    end else if (top_kind_next == bst_pkg::FK_DVAL) begin
                        top_kind_next = bst_pkg::FK_DKEY;
                    end
                    phase_next = bst_pkg::PH_VALUE;
                end
            end
            if (!halt_next && s_final_req) begin
                if (phase_next == bst_pkg::PH_ISIGN || phase_next == bst_pkg::PH_IDIG) begin
                    b_v = 1'b1;
                    res1 = bst_pkg::mk_res(bst_pkg::K_ERR, 64'd0, 1'b0, base_reg + pos_c,
                        32'd0, depth_next, bst_pkg::E_INT_END, 1'b0);
                end else if (phase_next == bst_pkg::PH_SLEN
                             || phase_next == bst_pkg::PH_SBODY) begin
                    b_v = 1'b1;
                    res1 = bst_pkg::mk_res(bst_pkg::K_ERR, 64'd0, 1'b0, base_reg + pos_c,
                        32'd0, depth_next, bst_pkg::E_STR_END, 1'b0);
                end else if (depth_next != '0) begin
                    b_v = 1'b1;
                    res1 = bst_pkg::mk_res(bst_pkg::K_UNTERM, 64'd0, 1'b0,
                        base_reg + root_next, pos_c - root_next + 32'd1, depth_next,
                        bst_pkg::E_ILLEGAL, 1'b0);
                end
            end
            if (s_final_req) begin
                halt_next = 1'b1;
            end
        end
    end

    // prefetch the frame below the next top
    assign mem_raddr = AW'(depth_next - DW'(2));
    assign fwd_next  = mem_we && (mem_waddr == mem_raddr);

    assign wr0 = a_v || b_v;
    assign wr1 = a_v && b_v;
    always_comb begin
        slot0 = a_v ? res0 : res1;
        slot0.last = !(a_v && b_v);
        slot1 = res1;
        slot1.last = 1'b1;
    end
    assign cnt_next = cnt_reg + 3'(wr0) + 3'(wr1) - 3'(out_acc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= '0;
            pos_reg       <= '0;
            depth_reg     <= '0;
            phase_reg     <= bst_pkg::PH_VALUE;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            rem_reg       <= '0;
            tok_reg       <= '0;
            halt_reg      <= 1'b0;
            top_kind_reg  <= bst_pkg::FK_DKEY;
            top_start_reg <= '0;
            root_reg      <= '0;
            fwd_reg       <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
            pos_reg       <= pos_next;
            depth_reg     <= depth_next;
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            seen_reg      <= seen_next;
            rem_reg       <= rem_next;
            tok_reg       <= tok_next;
            halt_reg      <= halt_next;
            top_kind_reg  <= top_kind_next;
            top_start_reg <= top_start_next;
            root_reg      <= root_next;
            fwd_reg       <= fwd_next;
            wr_ptr_reg    <= wr_ptr_reg + 2'(wr0) + 2'(wr1);
            rd_ptr_reg    <= rd_ptr_reg + 2'(out_acc);
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= mem_wdata;
        if (wr0) begin
            fifo_reg[wr_ptr_reg] <= slot0;
        end
        if (wr1) begin
            fifo_reg[wr_ptr_reg + 2'd1] <= slot1;
        end
    end

    assign head         = fifo_reg[rd_ptr_reg];
    assign m_kind       = head.kind;
    assign m_value      = signed'(head.value);
    assign m_wide       = head.wide;
    assign m_offset     = head.offset;
    assign m_length     = head.length;
    assign m_depth      = head.depth;
    assign m_error_code = head.error_code;
    assign m_is_key     = head.is_key;
    assign m_last       = head.last;

    `BST_ASSERT_NEXT(a_final_halts, aclk, aresetn, in_acc && s_final_req, halt_reg, "final transaction did not halt parsing")
    `BST_ASSERT_NOW(a_depth_bound, aclk, aresetn, 1'b1, depth_reg <= DW'(STACK_DEPTH), "stack depth beyond limit")
    `BST_ASSERT_NOW(a_queue_bound, aclk, aresetn, 1'b1, cnt_reg <= 3'd4, "result queue overflow")

endmodule
